[rtl/pidaw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// Types, register indexes, saturation helpers and the control program of the
// anti-windup PID controller.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W   = 4;

  typedef logic signed [DATA_W-1:0]   q_t;
  typedef logic signed [DATA_W+1:0]   wide_t;   // exact sum of up to three q_t
  typedef logic [DATA_W-2:0]          uq31_t;
  typedef logic [STEP_W-1:0]          step_t;

  // derivative clamp bound, Q16.16
  localparam q_t DERIV_LIMIT = 32'sh7FFF_FFFF;

  localparam wide_t SAT_MAX = 34'sh0_7FFF_FFFF;
  localparam wide_t SAT_MIN = 34'sh3_8000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN_DT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_PERIOD   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD_GAIN = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX       = 4'd7;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_SUB_SAT,    // sat(a - b)
    ALU_ADD_SAT,    // sat(a + b)
    ALU_MOVE,       // a
    ALU_ACC_CLAMP,  // clamp(sat(a + b), -integral_limit, integral_limit)
    ALU_DCLAMP,     // clamp(a, -DERIV_LIMIT, DERIV_LIMIT)
    ALU_AW_HI,      // pull integral down so prop + integral <= output_max
    ALU_AW_LO       // pull integral up so prop + integral >= output_min
  } alu_op_t;

  typedef enum logic [3:0] {
    SRC_ZERO, SRC_SP, SRC_MEAS, SRC_LAST, SRC_RATE,
    SRC_Q, SRC_T, SRC_PROP, SRC_INTEG
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_ERR, DST_T, DST_PROP, DST_INTEG, DST_D
  } dst_t;

  typedef enum logic [1:0] { MA_FF, MA_KP, MA_KI, MA_D } mul_a_t;
  typedef enum logic [1:0] { MB_SP, MB_ERR, MB_INVP, MB_KD } mul_b_t;

  typedef enum logic { JMP_NONE, JMP_IF_FIRST } jmp_t;

  typedef struct packed {
    alu_op_t alu_op;
    src_t    src_a;
    src_t    src_b;
    dst_t    dst;
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    jmp_t    jmp;
    step_t   jmp_to;
    logic    last;     // final step: form drive and retire the item
  } ctrl_word_t;

  localparam step_t STEP_ANTIWINDUP = 4'd9;

  function automatic q_t sat32(input wide_t v);
    if (v > SAT_MAX) begin
      return SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic wide_t wext(input q_t v);
    return {{2{v[DATA_W-1]}}, v};
  endfunction

  function automatic ctrl_word_t mk(input alu_op_t op, input src_t a, input src_t b,
                                    input dst_t d, input logic me, input mul_a_t ma,
                                    input mul_b_t mb, input jmp_t j, input step_t jt,
                                    input logic l);
    ctrl_word_t w;
    w.alu_op = op;
    w.src_a  = a;
    w.src_b  = b;
    w.dst    = d;
    w.mul_en = me;
    w.mul_a  = ma;
    w.mul_b  = mb;
    w.jmp    = j;
    w.jmp_to = jt;
    w.last   = l;
    return w;
  endfunction

  // control program
  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    w = mk(ALU_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b0, MA_FF, MB_SP,
           JMP_NONE, '0, 1'b0);
    case (s)
      4'd0:  w = mk(ALU_SUB_SAT, SRC_SP, SRC_MEAS, DST_ERR, 1'b1, MA_FF, MB_SP,
                    JMP_NONE, '0, 1'b0);
      4'd1:  w = mk(ALU_MOVE, SRC_Q, SRC_ZERO, DST_T, 1'b1, MA_KP, MB_ERR,
                    JMP_NONE, '0, 1'b0);
      4'd2:  w = mk(ALU_ADD_SAT, SRC_T, SRC_Q, DST_PROP, 1'b1, MA_KI, MB_ERR,
                    JMP_NONE, '0, 1'b0);
      4'd3:  w = mk(ALU_ACC_CLAMP, SRC_INTEG, SRC_Q, DST_INTEG, 1'b0, MA_FF, MB_SP,
                    JMP_IF_FIRST, STEP_ANTIWINDUP, 1'b0);
      4'd4:  w = mk(ALU_SUB_SAT, SRC_MEAS, SRC_LAST, DST_D, 1'b0, MA_FF, MB_SP,
                    JMP_NONE, '0, 1'b0);
      4'd5:  w = mk(ALU_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1, MA_D, MB_INVP,
                    JMP_NONE, '0, 1'b0);
      4'd6:  w = mk(ALU_SUB_SAT, SRC_RATE, SRC_Q, DST_D, 1'b0, MA_FF, MB_SP,
                    JMP_NONE, '0, 1'b0);
      4'd7:  w = mk(ALU_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b1, MA_D, MB_KD,
                    JMP_NONE, '0, 1'b0);
      4'd8:  w = mk(ALU_DCLAMP, SRC_Q, SRC_ZERO, DST_D, 1'b0, MA_FF, MB_SP,
                    JMP_NONE, '0, 1'b0);
      4'd9:  w = mk(ALU_AW_HI, SRC_PROP, SRC_INTEG, DST_INTEG, 1'b0, MA_FF, MB_SP,
                    JMP_NONE, '0, 1'b0);
      4'd10: w = mk(ALU_AW_LO, SRC_PROP, SRC_INTEG, DST_INTEG, 1'b0, MA_FF, MB_SP,
                    JMP_NONE, '0, 1'b0);
      4'd11: w = mk(ALU_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b0, MA_FF, MB_SP,
                    JMP_NONE, '0, 1'b1);
      default: w = mk(ALU_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, 1'b0, MA_FF, MB_SP,
                      JMP_NONE, '0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

[rtl/pid_controller_antiwindup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Q16.16 PID controller with feedforward, clamped integral and derivative,
// and anti-windup, run by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per control sample. tdata = measured, setpoint,
//            setpoint_rate; tuser = restart.
//   out_*  : one word per sample, the clamped drive value.
//   cfg_*  : register writes (index 0..7, others ignored), always ready;
//            write only while no sample is in flight.
// Timing:
//   A sample is taken while the sequencer is idle, then the program runs
//   12 steps (7 on the first sample after reset or with restart set, the
//   derivative steps are jumped over). The drive word appears the cycle after
//   the final step. The 32x32 multiplier is shared by all five products and
//   each product is registered before use, which sets the step count.
// Reset:
//   Registers take their reset values, integral and last measured clear, and
//   the next sample counts as a first sample.
// Stall:
//   A drive word waits in the output register; if it is not yet taken when
//   the next sample reaches its final step, the sequencer holds there.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] measured, [63:32] setpoint, [95:64] setpoint_rate
  input  logic [95:0]                      in_tdata,
  // [0] restart
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] drive
  output logic [31:0]                      out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);
  import pidaw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // configuration
  q_t    prop_gain_r, ki_dt_r, deriv_gain_r, ff_gain_r, out_min_r, out_max_r;
  uq31_t inv_period_r, int_limit_r;

  // persistent state
  q_t   integ_r, last_meas_r;
  logic first_r;

  // per-sample working registers
  q_t   meas_r, sp_r, rate_r, err_r, t_r, prop_r, d_r, drive_r;
  logic restart_r;
  logic signed [2*DATA_W-1:0] prod_r;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;

  ctrl_word_t cw;
  logic   run, stall, exec, fire_out, in_acc, jump;
  q_t     q_val, alu_a, alu_b, alu_res, mul_a, mul_b;
  wide_t  sum_ab, diff_ab, sum3;
  q_t     neg_lim;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = drive_r;

  assign cw       = ucode_rom(step_r);
  assign run      = (state_r == ST_RUN);
  assign stall    = cw.last & out_valid_r & ~out_tready;
  assign exec     = run & ~stall;
  assign fire_out = exec & cw.last;
  assign jump     = (cw.jmp == JMP_IF_FIRST) & (first_r | restart_r);

  // product >>> 16 saturated to 32 bits
  always_comb begin
    if (prod_r[2*DATA_W-1:DATA_W+15] == {(DATA_W-15){1'b0}} ||
        prod_r[2*DATA_W-1:DATA_W+15] == {(DATA_W-15){1'b1}}) begin
      q_val = prod_r[DATA_W+15:16];
    end else if (prod_r[2*DATA_W-1]) begin
      q_val = SAT_MIN[DATA_W-1:0];
    end else begin
      q_val = SAT_MAX[DATA_W-1:0];
    end
  end

  // operand selection
  always_comb begin
    case (cw.src_a)
      SRC_SP:    alu_a = sp_r;
      SRC_MEAS:  alu_a = meas_r;
      SRC_LAST:  alu_a = last_meas_r;
      SRC_RATE:  alu_a = rate_r;
      SRC_Q:     alu_a = q_val;
      SRC_T:     alu_a = t_r;
      SRC_PROP:  alu_a = prop_r;
      SRC_INTEG: alu_a = integ_r;
      default:   alu_a = '0;
    endcase
    case (cw.src_b)
      SRC_SP:    alu_b = sp_r;
      SRC_MEAS:  alu_b = meas_r;
      SRC_LAST:  alu_b = last_meas_r;
      SRC_RATE:  alu_b = rate_r;
      SRC_Q:     alu_b = q_val;
      SRC_T:     alu_b = t_r;
      SRC_PROP:  alu_b = prop_r;
      SRC_INTEG: alu_b = integ_r;
      default:   alu_b = '0;
    endcase
    case (cw.mul_a)
      MA_FF:   mul_a = ff_gain_r;
      MA_KP:   mul_a = prop_gain_r;
      MA_KI:   mul_a = ki_dt_r;
      default: mul_a = d_r;
    endcase
    case (cw.mul_b)
      MB_SP:   mul_b = sp_r;
      MB_ERR:  mul_b = err_r;
      MB_INVP: mul_b = {1'b0, inv_period_r};
      default: mul_b = deriv_gain_r;
    endcase
  end

  // ALU
  assign sum_ab  = wext(alu_a) + wext(alu_b);
  assign diff_ab = wext(alu_a) - wext(alu_b);
  assign neg_lim = -{1'b0, int_limit_r};
  assign sum3    = wext(prop_r) + wext(integ_r) + wext(d_r);

  always_comb begin
    q_t acc;
    acc = sat32(sum_ab);
    case (cw.alu_op)
      ALU_SUB_SAT: alu_res = sat32(diff_ab);
      ALU_ADD_SAT: alu_res = acc;
      ALU_MOVE:    alu_res = alu_a;
      ALU_ACC_CLAMP: begin
        if (acc < neg_lim) begin
          alu_res = neg_lim;
        end else if (acc > $signed({1'b0, int_limit_r})) begin
          alu_res = {1'b0, int_limit_r};
        end else begin
          alu_res = acc;
        end
      end
      ALU_DCLAMP: begin
        if (alu_a < -DERIV_LIMIT) begin
          alu_res = -DERIV_LIMIT;
        end else if (alu_a > DERIV_LIMIT) begin
          alu_res = DERIV_LIMIT;
        end else begin
          alu_res = alu_a;
        end
      end
      ALU_AW_HI: begin
        if (out_min_r != out_max_r && sum_ab > wext(out_max_r)) begin
          alu_res = sat32(wext(out_max_r) - wext(alu_a));
        end else begin
          alu_res = alu_b;
        end
      end
      ALU_AW_LO: begin
        if (out_min_r != out_max_r && sum_ab < wext(out_min_r)) begin
          alu_res = sat32(wext(out_min_r) - wext(alu_a));
        end else begin
          alu_res = alu_b;
        end
      end
      default: alu_res = alu_b;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (exec) begin
          if (cw.last) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end else if (jump) begin
            step_nxt = cw.jmp_to;
          end else begin
            step_nxt = step_r + step_t'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      first_r      <= 1'b1;
      integ_r      <= '0;
      last_meas_r  <= '0;
      prop_gain_r  <= '0;
      ki_dt_r      <= '0;
      deriv_gain_r <= '0;
      inv_period_r <= uq31_t'(65536);
      ff_gain_r    <= '0;
      int_limit_r  <= '0;
      out_min_r    <= '0;
      out_max_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec && cw.dst == DST_INTEG) begin
        integ_r <= alu_res;
      end
      if (fire_out) begin
        first_r     <= 1'b0;
        last_meas_r <= meas_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:        prop_gain_r  <= cfg_data;
          REG_INTEGRAL_GAIN_DT: ki_dt_r      <= cfg_data;
          REG_DERIV_GAIN:       deriv_gain_r <= cfg_data;
          REG_INVERSE_PERIOD:   inv_period_r <= cfg_data[DATA_W-2:0];
          REG_FEEDFORWARD_GAIN: ff_gain_r    <= cfg_data;
          REG_INTEGRAL_LIMIT:   int_limit_r  <= cfg_data[DATA_W-2:0];
          REG_OUTPUT_MIN:       out_min_r    <= cfg_data;
          REG_OUTPUT_MAX:       out_max_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r    <= in_tdata[31:0];
      sp_r      <= in_tdata[63:32];
      rate_r    <= in_tdata[95:64];
      restart_r <= in_tuser[0];
      d_r       <= '0;   // stays zero when the derivative steps are skipped
    end else if (exec) begin
      case (cw.dst)
        DST_ERR:  err_r  <= alu_res;
        DST_T:    t_r    <= alu_res;
        DST_PROP: prop_r <= alu_res;
        DST_D:    d_r    <= alu_res;
        default: ;
      endcase
    end
    if (exec && cw.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (fire_out) begin
      // exact three-term sum, min checked first
      if (sum3 < wext(out_min_r)) begin
        drive_r <= out_min_r;
      end else if (sum3 > wext(out_max_r)) begin
        drive_r <= out_max_r;
      end else begin
        drive_r <= sum3[DATA_W-1:0];
      end
    end
  end

endmodule
